[rtl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the cubic bezier flattener
// Field widths, step limits, fixed-point sizes and the structs that travel
// between the length unit, the point pipeline and the top level.
// ----------------------------------------------------------------------------
package cbf_pkg;

   // coordinate and register widths
   localparam int COORD_W = 32;
   localparam int TOL_W   = 31;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

   // step count limit and derived sizes
   localparam int MAX_STEPS = 63;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int D_W       = STEP_W + 1;          // d = 2*steps, n = 2s+1
   localparam int P2_W      = 2 * D_W;             // products of two factors
   localparam int W_W       = 3 * D_W;             // bernstein weights, d^3

   // leg length unit
   localparam int MAG_W  = COORD_W;                // |dx| < 2^32
   localparam int SQ_W   = 2 * MAG_W + 1;          // dx^2 + dy^2
   localparam int LEN_W  = MAG_W + 1;              // floor of the root
   localparam int RAD_W  = 2 * LEN_W;
   localparam int REM_W  = LEN_W + 2;
   localparam int SUM_W  = LEN_W + 2;              // three legs
   localparam int ITER_W = $clog2(LEN_W);
   localparam int DV_W   = TOL_W + STEP_W + 1;

   // point pipeline
   localparam int PR_W   = COORD_W + W_W + 1;      // coordinate times weight
   localparam int NS_W   = PR_W + 3;               // biased numerator, signed
   localparam int NW     = COORD_W + W_W + 1;      // biased numerator, unsigned
   localparam int RW     = NW - COORD_W;           // divider remainder
   localparam int QB     = 4;                      // quotient bits per stage
   localparam int DIV_N  = COORD_W / QB;
   localparam logic [COORD_W-1:0] SIGN_FLIP = COORD_W'(1) << (COORD_W - 1);

   typedef logic signed [COORD_W-1:0] coord_type;

   // control points: index 0 start, 1 ctrl a, 2 ctrl b, 3 end
   typedef struct packed {
      coord_type [3:0] x;
      coord_type [3:0] y;
   } curve_type;

   // length unit status toward the sequencer
   typedef struct packed {
      logic              done;
      logic              short_curve;
      logic [STEP_W-1:0] steps;
   } len_stat_type;

   // one point request into the pipeline
   typedef struct packed {
      logic           valid;
      logic           last;
      logic [D_W-1:0] n;
      logic [D_W-1:0] d;
   } tok_type;

endpackage

[rtl/cbf_if.sv]
// ----------------------------------------------------------------------------
// cbf_if: item channels of the cubic bezier flattener
// Valid/ready channels for curves in and polyline points out.
// ----------------------------------------------------------------------------
interface cbf_req_if;
   import cbf_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type ctrl_a_x;
   coord_type ctrl_a_y;
   coord_type ctrl_b_x;
   coord_type ctrl_b_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
                   ctrl_b_x, ctrl_b_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
                 ctrl_b_x, ctrl_b_y, end_x, end_y, output ready);
endinterface

interface cbf_rsp_if;
   import cbf_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[rtl/cbf_len.sv]
// ----------------------------------------------------------------------------
// cbf_len: control polygon length and step count
// Squares each leg with one shared multiplier, takes a bit-serial integer
// square root, sums the three legs and divides by the tolerance bit by bit.
// ----------------------------------------------------------------------------
module cbf_len (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  cbf_pkg::curve_type         curve,
   input  logic [cbf_pkg::TOL_W-1:0]  tolerance,
   output cbf_pkg::len_stat_type      status
);
   import cbf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        leg_ff, leg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  drem_ff, drem_in;
   logic [STEP_W:0]   quot_ff, quot_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   logic [1:0]           leg_nxt;
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]     neg_diff;
   logic [MAG_W-1:0]     mag;
   logic [2*MAG_W-1:0]   prod;
   logic [SQ_W-1:0]      sq_sum;
   logic [REM_W+1:0]     rem2, trial, rem_sub;
   logic                 root_ge;
   logic [DV_W-1:0]      shifted, dsub;
   logic                 div_ge;

   // leg difference of the selected axis and its square
   always_comb begin
      leg_nxt = leg_ff + 2'd1;
      if (state_ff == ST_SQY)
         diff = {curve.y[leg_nxt][COORD_W-1], curve.y[leg_nxt]}
              - {curve.y[leg_ff][COORD_W-1], curve.y[leg_ff]};
      else
         diff = {curve.x[leg_nxt][COORD_W-1], curve.x[leg_nxt]}
              - {curve.x[leg_ff][COORD_W-1], curve.x[leg_ff]};
      neg_diff = -diff;
      mag  = diff[COORD_W] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
      prod = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
      sq_sum = sq_ff + SQ_W'(prod);
   end

   // one root digit per cycle
   always_comb begin
      rem2    = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      root_ge = rem2 >= trial;
      rem_sub = rem2 - trial;
   end

   // one quotient bit per cycle
   always_comb begin
      shifted = DV_W'(tolerance) << iter_ff;
      div_ge  = DV_W'(drem_ff) >= shifted;
      dsub    = DV_W'(drem_ff) - shifted;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      leg_in   = leg_ff;
      iter_in  = iter_ff;
      sq_in    = sq_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      sum_in   = sum_ff;
      drem_in  = drem_ff;
      quot_in  = quot_ff;
      steps_in = steps_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               leg_in   = 2'd0;
               sum_in   = '0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sq_in    = SQ_W'(prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = RAD_W'(sq_sum);
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = root_ge ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
            root_in = {root_ff[LEN_W-2:0], root_ge};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(LEN_W - 1)) begin
               sum_in = sum_ff + SUM_W'({root_ff[LEN_W-2:0], root_ge});
               if (leg_ff == 2'd2) begin
                  drem_in  = sum_ff + SUM_W'({root_ff[LEN_W-2:0], root_ge});
                  quot_in  = '0;
                  iter_in  = ITER_W'(STEP_W);
                  state_in = ST_DIV;
               end else begin
                  leg_in   = leg_nxt;
                  state_in = ST_SQX;
               end
            end
         end
         ST_DIV: begin
            drem_in = div_ge ? dsub[SUM_W-1:0] : drem_ff;
            quot_in = quot_ff | ((STEP_W+1)'(div_ge) << iter_ff);
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               // saturate: quotient plus one never passes the limit
               if (quot_in >= (STEP_W+1)'(MAX_STEPS - 1))
                  steps_in = STEP_W'(MAX_STEPS);
               else
                  steps_in = quot_in[STEP_W-1:0] + STEP_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      leg_ff   <= leg_in;
      iter_ff  <= iter_in;
      sq_ff    <= sq_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sum_ff   <= sum_in;
      drem_ff  <= drem_in;
      quot_ff  <= quot_in;
      steps_ff <= steps_in;
   end

   // status toward the sequencer
   always_comb begin
      status.done        = state_ff == ST_DONE;
      status.short_curve = sum_ff < SUM_W'(tolerance);
      status.steps       = steps_ff;
   end

endmodule

[rtl/cbf_pnt.sv]
// ----------------------------------------------------------------------------
// cbf_pnt: curve point pipeline
// Bernstein weights, weighted sum of the control points and a pipelined
// restoring divider by d^3, round half up; one point per cycle unless held.
// ----------------------------------------------------------------------------
module cbf_pnt (
   input  logic               clock,
   input  logic               reset,
   input  cbf_pkg::tok_type   tok,
   input  cbf_pkg::curve_type curve,
   output logic               in_ready,
   cbf_rsp_if.source          rsp
);
   import cbf_pkg::*;

   logic adv;

   // stage 1: squares and cross product of m and n, and d^2
   logic              v1_ff, last1_ff;
   logic [D_W-1:0]    m_in, m1_ff, n1_ff, d1_ff;
   logic [P2_W-1:0]   mm1_ff, mn1_ff, nn1_ff, dd1_ff;
   curve_type         curve1_ff;

   // stage 2: weights and d^3
   logic              v2_ff, last2_ff;
   logic [W_W-1:0]    w_in [4];
   logic [W_W-1:0]    w2_ff [4];
   logic [W_W-1:0]    d3_in, d32_ff;
   curve_type         curve2_ff;

   // stage 3: weighted coordinates
   logic              v3_ff, last3_ff;
   logic signed [PR_W-1:0] prx_in [4], pry_in [4];
   logic signed [PR_W-1:0] prx3_ff [4], pry3_ff [4];
   logic [W_W-1:0]    d33_ff;

   // stage 4: biased numerators
   logic              v4_ff, last4_ff;
   logic signed [NS_W-1:0] sumx, sumy, d3s, nfx, nfy;
   logic [NW-1:0]     nx4_ff, ny4_ff;
   logic [RW-1:0]     dsr4_ff;

   // divider stages
   logic              dv_ff [DIV_N];
   logic              dlast_ff [DIV_N];
   logic [RW-1:0]     ddsr_ff [DIV_N];
   logic [RW-1:0]     drem_ff [DIV_N][2];
   logic [COORD_W-1:0] dword_ff [DIV_N][2];

   logic              vld_q [DIV_N+1];
   logic              last_q [DIV_N+1];
   logic [RW-1:0]     dsr_q [DIV_N+1];
   logic [RW-1:0]     rem_q [DIV_N+1][2];
   logic [COORD_W-1:0] word_q [DIV_N+1][2];

   // the whole pipe moves unless the output register is held
   assign adv      = !dv_ff[DIV_N-1] || rsp.ready;
   assign in_ready = adv;

   // stage 1
   assign m_in = tok.d - tok.n;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= tok.valid;
      end
      if (adv) begin
         last1_ff  <= tok.last;
         m1_ff     <= m_in;
         n1_ff     <= tok.n;
         d1_ff     <= tok.d;
         mm1_ff    <= P2_W'(m_in) * P2_W'(m_in);
         mn1_ff    <= P2_W'(m_in) * P2_W'(tok.n);
         nn1_ff    <= P2_W'(tok.n) * P2_W'(tok.n);
         dd1_ff    <= P2_W'(tok.d) * P2_W'(tok.d);
         curve1_ff <= curve;
      end
   end

   // stage 2
   always_comb begin
      w_in[0] = W_W'(mm1_ff) * W_W'(m1_ff);
      w_in[1] = W_W'(3) * W_W'(mm1_ff) * W_W'(n1_ff);
      w_in[2] = W_W'(3) * W_W'(mn1_ff) * W_W'(n1_ff);
      w_in[3] = W_W'(nn1_ff) * W_W'(n1_ff);
      d3_in   = W_W'(dd1_ff) * W_W'(d1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         last2_ff  <= last1_ff;
         w2_ff     <= w_in;
         d32_ff    <= d3_in;
         curve2_ff <= curve1_ff;
      end
   end

   // stage 3
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prx_in[k] = PR_W'($signed(curve2_ff.x[k])) * PR_W'($signed({1'b0, w2_ff[k]}));
         pry_in[k] = PR_W'($signed(curve2_ff.y[k])) * PR_W'($signed({1'b0, w2_ff[k]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         last3_ff <= last2_ff;
         prx3_ff  <= prx_in;
         pry3_ff  <= pry_in;
         d33_ff   <= d32_ff;
      end
   end

   // stage 4: 2*num + d^3 + 2^32*d^3, kept nonnegative
   always_comb begin
      sumx = NS_W'(prx3_ff[0]) + NS_W'(prx3_ff[1]) + NS_W'(prx3_ff[2]) + NS_W'(prx3_ff[3]);
      sumy = NS_W'(pry3_ff[0]) + NS_W'(pry3_ff[1]) + NS_W'(pry3_ff[2]) + NS_W'(pry3_ff[3]);
      d3s  = NS_W'($signed({1'b0, d33_ff}));
      nfx  = (sumx <<< 1) + d3s + (d3s <<< COORD_W);
      nfy  = (sumy <<< 1) + d3s + (d3s <<< COORD_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         last4_ff <= last3_ff;
         nx4_ff   <= nfx[NW-1:0];
         ny4_ff   <= nfy[NW-1:0];
         dsr4_ff  <= {d33_ff, 1'b0};
      end
   end

   // divider feed: high part is the starting remainder
   assign vld_q[0]     = v4_ff;
   assign last_q[0]    = last4_ff;
   assign dsr_q[0]     = dsr4_ff;
   assign rem_q[0][0]  = nx4_ff[NW-1:COORD_W];
   assign rem_q[0][1]  = ny4_ff[NW-1:COORD_W];
   assign word_q[0][0] = nx4_ff[COORD_W-1:0];
   assign word_q[0][1] = ny4_ff[COORD_W-1:0];

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [RW-1:0]      r_in [2];
      logic [COORD_W-1:0] w_nx [2];

      // QB restoring steps; the word shifts dividend bits out, quotient in
      always_comb begin
         logic [RW-1:0]      r;
         logic [COORD_W-1:0] w;
         logic [RW:0]        t;
         logic [RW:0]        dif;
         logic               ge;
         for (int a = 0; a < 2; a++) begin
            r = rem_q[j][a];
            w = word_q[j][a];
            for (int b = 0; b < QB; b++) begin
               t   = {r, w[COORD_W-1]};
               dif = t - {1'b0, dsr_q[j]};
               ge  = t >= {1'b0, dsr_q[j]};
               r   = ge ? dif[RW-1:0] : t[RW-1:0];
               w   = {w[COORD_W-2:0], ge};
            end
            r_in[a] = r;
            w_nx[a] = w;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= vld_q[j];
         end
         if (adv) begin
            dlast_ff[j] <= last_q[j];
            ddsr_ff[j]  <= dsr_q[j];
            drem_ff[j]  <= r_in;
            dword_ff[j] <= w_nx;
         end
      end

      assign vld_q[j+1]     = dv_ff[j];
      assign last_q[j+1]    = dlast_ff[j];
      assign dsr_q[j+1]     = ddsr_ff[j];
      assign rem_q[j+1][0]  = drem_ff[j][0];
      assign rem_q[j+1][1]  = drem_ff[j][1];
      assign word_q[j+1][0] = dword_ff[j][0];
      assign word_q[j+1][1] = dword_ff[j][1];
   end

   // quotient carries a 2^31 bias: flip the top bit
   assign rsp.valid      = vld_q[DIV_N];
   assign rsp.last_point = last_q[DIV_N];
   assign rsp.point_x    = $signed(word_q[DIV_N][0] ^ SIGN_FLIP);
   assign rsp.point_y    = $signed(word_q[DIV_N][1] ^ SIGN_FLIP);

endmodule

[rtl/cubic_bezier_flattener_top.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_top: cubic bezier curve to polyline points
// Measures the control polygon, picks a step count from the tolerance and
// emits evenly spaced curve points followed by the end point.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        four control points, signed Q16.16
//   rsp_chan  out  valid/ready        point_x, point_y, last_point
//   csr       in   csr_write_en       csr_write_data: tolerance, Q16.16
//
// One curve at a time: measuring takes three legs of two squares and a serial
// square root each, a bit-serial divide and a done state; it then issues
// steps + 1 point requests into the point pipeline. The serial square root
// dominates the measuring. Reset clears control state and sets the tolerance
// to 1.0. A held result stalls the whole point pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [cbf_pkg::TOL_W-1:0] csr_write_data,
   cbf_req_if.sink                   req_chan,
   cbf_rsp_if.source                 rsp_chan
);
   import cbf_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LEN   = 2'd1;
   localparam logic [1:0] S_ISSUE = 2'd2;

   logic [1:0]        seq_ff, seq_in;
   logic [TOL_W-1:0]  tol_ff;
   curve_type         curve_ff;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [STEP_W-1:0] s_ff, s_in;
   logic [D_W-1:0]    d_ff, d_in;

   logic              accept;
   logic              pnt_ready;
   len_stat_type      status;
   tok_type           tok;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   // input item capture
   assign req_chan.ready = seq_ff == S_IDLE;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         curve_ff.x[0] <= req_chan.start_x;
         curve_ff.y[0] <= req_chan.start_y;
         curve_ff.x[1] <= req_chan.ctrl_a_x;
         curve_ff.y[1] <= req_chan.ctrl_a_y;
         curve_ff.x[2] <= req_chan.ctrl_b_x;
         curve_ff.y[2] <= req_chan.ctrl_b_y;
         curve_ff.x[3] <= req_chan.end_x;
         curve_ff.y[3] <= req_chan.end_y;
      end
   end

   cbf_len u_len (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .curve     (curve_ff),
      .tolerance (tol_ff),
      .status    (status)
   );

   // point request; the end point goes through as n = d
   always_comb begin
      tok.valid = seq_ff == S_ISSUE;
      tok.last  = s_ff == steps_ff;
      tok.d     = d_ff;
      tok.n     = tok.last ? d_ff : {s_ff, 1'b1};
   end

   // issue sequencer
   always_comb begin
      seq_in   = seq_ff;
      steps_in = steps_ff;
      s_in     = s_ff;
      d_in     = d_ff;
      case (seq_ff)
         S_IDLE: begin
            if (accept) seq_in = S_LEN;
         end
         S_LEN: begin
            if (status.done) begin
               s_in   = '0;
               seq_in = S_ISSUE;
               if (status.short_curve) begin
                  steps_in = '0;
                  d_in     = D_W'(2);
               end else begin
                  steps_in = status.steps;
                  d_in     = {status.steps, 1'b0};
               end
            end
         end
         S_ISSUE: begin
            if (pnt_ready) begin
               if (tok.last) seq_in = S_IDLE;
               else          s_in   = s_ff + STEP_W'(1);
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE;
      end else begin
         seq_ff <= seq_in;
      end
      steps_ff <= steps_in;
      s_ff     <= s_in;
      d_ff     <= d_in;
   end

   cbf_pnt u_pnt (
      .clock    (clock),
      .reset    (reset),
      .tok      (tok),
      .curve    (curve_ff),
      .in_ready (pnt_ready),
      .rsp      (rsp_chan)
   );

   // the length unit reports only while a curve is being measured
   a_done_in_len: assert property (@(posedge clock) disable iff (reset)
      status.done |-> seq_ff == S_LEN)
      else $error("length unit finished outside the measure phase");

   // an accepted curve always starts the measure phase
   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      accept |=> seq_ff == S_LEN)
      else $error("accepted curve did not start measuring");

   // the closing request always asks for the end point
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      tok.valid && tok.last |-> tok.n == tok.d)
      else $error("closing request is not the end point");

   // interior requests stay strictly inside the curve
   a_interior: assert property (@(posedge clock) disable iff (reset)
      tok.valid && !tok.last |-> tok.n < tok.d)
      else $error("interior request outside the curve");

endmodule
